// ----- design/v3n_pkg.sv -----
// v3n_pkg: shared types and constants for the vector normaliser
// no dependencies
package v3n_pkg;

    localparam int COMP_BITS_DEF     = 16;
    localparam int FRAC_OUT_BITS_DEF = 14;
    localparam logic [15:0] THRESH_RESET = 16'd1;
    localparam logic [0:0]  ADDR_THRESH  = 1'b0;

    typedef struct packed {
        logic signed [15:0] comp_x;
        logic signed [15:0] comp_y;
        logic signed [15:0] comp_z;
    } v3n_in_t;

    typedef struct packed {
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic signed [15:0] unit_z;
        logic [15:0]        length;
        logic               was_zeroed;
    } v3n_out_t;

endpackage

// ----- design/vector3_normalize.sv -----
// vector3_normalize: pipelined 3d vector normaliser, q8.8 in, q1.14 out
// depends on v3n_pkg
//
// pipeline: abs, sum of squares, square root, divider and output stages, in that order
// throughput: one request per cycle; a stall freezes every stage together
// square root is one digit per stage (17 stages), division one quotient bit
// per stage (30 stages, three lanes side by side)
// reset: rst_n asynchronous active low clears valid bits and sets the
// threshold to one; payload registers are not reset
module vector3_normalize
    import v3n_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  v3n_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output v3n_out_t    out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // widths are fixed by the request and result structs in the package
    localparam int COMP_BITS     = COMP_BITS_DEF;
    localparam int FRAC_OUT_BITS = FRAC_OUT_BITS_DEF;

    // magnitude of a component needs COMP_BITS bits, square 2*COMP_BITS,
    // sum of three squares two more
    localparam int MB  = COMP_BITS;
    localparam int SB  = 2 * COMP_BITS + 2;
    localparam int RS  = (SB + 1) / 2;          // root digits
    localparam int RB  = RS;                    // root width
    localparam int NB  = MB + FRAC_OUT_BITS;    // dividend width
    localparam int QS  = NB;                    // quotient bits
    localparam int LAT = 2 + RS + QS + 1;
    localparam logic [NB:0] ONE_Q = (NB + 1)'(1) << FRAC_OUT_BITS;

    // ---------------- configuration ----------------
    logic [15:0] thresh_reg;
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= THRESH_RESET;
        else if (psel && penable && pwrite && paddr[2] == ADDR_THRESH && paddr[1:0] == 2'b00)
            thresh_reg <= pwdata[15:0];
    end
    assign prdata = (paddr[2] == ADDR_THRESH) ? {16'd0, thresh_reg} : 32'd0;

    // ---------------- global advance ----------------
    logic            adv;
    logic [LAT-1:0]  vld_reg;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // ---------------- stage a: abs and sign ----------------
    logic [MB-1:0] ma_reg [3];
    logic [2:0]    neg_reg [LAT];
    logic [MB-1:0] cin [3];
    assign cin[0] = in_data.comp_x[MB-1:0];
    assign cin[1] = in_data.comp_y[MB-1:0];
    assign cin[2] = in_data.comp_z[MB-1:0];

    // ---------------- stage b: squares summed ----------------
    logic [SB-1:0] sq_reg;

    // magnitudes carried along the whole pipe
    logic [MB-1:0] mag_reg [LAT][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ma_reg[i] <= cin[i][MB-1] ? MB'(-cin[i]) : cin[i];
                neg_reg[0][i] <= cin[i][MB-1];
                mag_reg[0][i] <= cin[i][MB-1] ? MB'(-cin[i]) : cin[i];
            end
            sq_reg <= SB'(ma_reg[0] * ma_reg[0]) + SB'(ma_reg[1] * ma_reg[1])
                    + SB'(ma_reg[2] * ma_reg[2]);
            for (int s = 1; s < LAT; s++)
            begin
                neg_reg[s] <= neg_reg[s-1];
                mag_reg[s] <= mag_reg[s-1];
            end
        end
    end

    // ---------------- square root, one digit a stage ----------------
    logic [SB-1:0] rem_reg  [RS];
    logic [RB-1:0] root_reg [RS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < RS; s++)
            begin : sq_stage
                logic [SB-1:0] rin;
                logic [RB-1:0] qin;
                logic [SB+1:0] trial;
                logic [SB+1:0] cur;
                rin = (s == 0) ? sq_reg : rem_reg[s-1];
                qin = (s == 0) ? '0 : root_reg[s-1];
                // remainder holds sum; compare (4*q+1) << 2*(RS-1-s)
                trial = ((SB+2)'({qin, 2'b01})) << (2 * (RS - 1 - s));
                cur   = (SB+2)'(rin);
                if (cur >= trial)
                begin
                    rem_reg[s]  <= SB'(cur - trial);
                    root_reg[s] <= RB'({qin, 1'b1});
                end
                else
                begin
                    rem_reg[s]  <= rin;
                    root_reg[s] <= RB'({qin, 1'b0});
                end
            end
        end
    end

    logic [RB-1:0] len_w;
    assign len_w = root_reg[RS-1];

    // length and zero flag carried through the divider
    logic [RB-1:0] len_reg [QS];
    logic          zr_reg  [QS];
    logic [NB:0]   qr_reg  [QS][3];
    logic [NB:0]   dr_reg  [QS][3];   // partial remainder

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < QS; s++)
            begin : dv_stage
                logic [RB-1:0] l;
                logic [NB+RB:0] r;
                l = (s == 0) ? len_w : len_reg[s-1];
                len_reg[s] <= l;
                zr_reg[s]  <= (s == 0) ? (len_w == '0 || len_w < RB'(thresh_reg))
                                       : zr_reg[s-1];
                for (int i = 0; i < 3; i++)
                begin
                    logic [NB-1:0] n;
                    logic [NB:0]   rp, qp;
                    n  = NB'(mag_reg[2 + RS - 1 + s][i]) << FRAC_OUT_BITS;
                    rp = (s == 0) ? '0 : dr_reg[s-1][i];
                    qp = (s == 0) ? '0 : qr_reg[s-1][i];
                    r  = (NB+RB+1)'({rp, n[NB-1-s]});
                    if (r >= (NB+RB+1)'(l))
                    begin
                        dr_reg[s][i] <= (NB+1)'(r - (NB+RB+1)'(l));
                        qr_reg[s][i] <= (NB+1)'({qp, 1'b1});
                    end
                    else
                    begin
                        dr_reg[s][i] <= (NB+1)'(r);
                        qr_reg[s][i] <= (NB+1)'({qp, 1'b0});
                    end
                end
            end
        end
    end

    // ---------------- output stage: saturate, sign, zero ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin : out_stage
            logic [NB:0] q [3];
            logic [15:0] u [3];
            for (int i = 0; i < 3; i++)
            begin
                q[i] = (qr_reg[QS-1][i] > ONE_Q) ? ONE_Q : qr_reg[QS-1][i];
                u[i] = neg_reg[LAT-2][i] ? 16'(-q[i]) : 16'(q[i]);
                if (zr_reg[QS-1])
                    u[i] = '0;
            end
            out_data.unit_x     <= u[0];
            out_data.unit_y     <= u[1];
            out_data.unit_z     <= u[2];
            out_data.length     <= 16'(len_reg[QS-1]);
            out_data.was_zeroed <= zr_reg[QS-1];
        end
    end

endmodule

// ----- dv/vector3_normalize_test.sv -----
// vector3_normalize_test: self-checking testbench for the 3d vector normaliser
// drives requests and apb writes, predicts or types in each result and compares it in order
// depends on v3n_pkg and design/vector3_normalize.sv
module vector3_normalize_test;
    import v3n_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // drain time exceeds the depth of the design pipeline, with margin
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int WATCH_LIMIT  = 3000;
    localparam int RAND_PER_SET = 330;
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    v3n_in_t     in_data;
    logic        out_valid;
    logic        out_stall;
    v3n_out_t    out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // directed row: request plus a typed-in result where it is obvious
    typedef struct {
        v3n_in_t  req;
        bit       known;
        v3n_out_t res;
    } dir_row_t;

    v3n_out_t    pending_units[$];
    logic [15:0] cur_thresh;
    int          err_cnt;
    bit          hold_req;
    bit          send_burst;
    bit          recv_burst;
    int          idle_cnt;
    dir_row_t    dir_rows[14];

    vector3_normalize u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // floor square root, digit by digit
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 34;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // expected unit vector, magnitude and zero flag for one request
    function automatic v3n_out_t normalise_vec(v3n_in_t v, logic [15:0] thr);
        logic signed [15:0] comp [3];
        longint             mag [3];
        longint             quo [3];
        longint unsigned    sum;
        longint unsigned    len;
        v3n_out_t           r;
        comp[0] = v.comp_x;
        comp[1] = v.comp_y;
        comp[2] = v.comp_z;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (comp[i] < 0) ? -longint'(comp[i]) : longint'(comp[i]);
            sum    = sum + mag[i] * mag[i];
        end
        len = root_floor(sum);
        for (int i = 0; i < 3; i++)
        begin
            // below threshold and zero length both force the zero vector
            if (len == 0 || len < thr)
                quo[i] = 0;
            else
            begin
                quo[i] = (mag[i] << 14) / len;
                if (quo[i] > 16384)
                    quo[i] = 16384;
                if (comp[i] < 0)
                    quo[i] = -quo[i];
            end
        end
        r.unit_x     = quo[0][15:0];
        r.unit_y     = quo[1][15:0];
        r.unit_z     = quo[2][15:0];
        r.length     = len[15:0];
        r.was_zeroed = (len == 0 || len < thr);
        return r;
    endfunction

    function automatic logic [15:0] pick_comp(int mode);
        case (mode)
            0:       return 16'($urandom_range(0, 1023)) - 16'd512;
            1:       return 16'($urandom_range(0, 4)) - 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly full range, some small vectors near the threshold, some single-axis extremes, some near zero
    function automatic v3n_in_t pick_request();
        v3n_in_t v;
        int      sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            v = '{pick_comp(2), pick_comp(2), pick_comp(2)};
        else if (sel < 8)
            v = '{pick_comp(0), pick_comp(0), pick_comp(0)};
        else if (sel == 8)
        begin
            v = '{16'd0, 16'd0, 16'd0};
            case ($urandom_range(0, 2))
                0:       v.comp_x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                1:       v.comp_y = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                default: v.comp_z = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            endcase
        end
        else
            v = '{pick_comp(1), pick_comp(1), pick_comp(1)};
        return v;
    endfunction

    // register write: setup cycle then access cycle
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only the threshold register exists, other addresses are dropped
        if (addr == 3'(ADDR_THRESH))
            cur_thresh = data[15:0];
    endtask

    // wait for every result, then let the pipe drain before touching config
    task automatic wait_idle();
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // offer one request after a random gap (none during a burst), hold it until accepted
    task automatic push_request(v3n_in_t v, bit known, v3n_out_t res);
        int gap;
        if ($urandom_range(0, 31) == 0)
            send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        do
            @(posedge clk);
        while (in_stall);
        pending_units.push_back(known ? res : normalise_vec(v, cur_thresh));
    endtask

    // receiver: random stall per result, plus one long hold-off on request
    initial
    begin
        int gap;
        out_stall  = 1'b1;
        recv_burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            else
            begin
                if ($urandom_range(0, 31) == 0)
                    recv_burst = ~recv_burst;
                gap = recv_burst ? 0 : $urandom_range(0, 16);
            end
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        v3n_out_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_units.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result %p", out_data);
            end
            else
            begin
                exp_res = pending_units.pop_front();
                if (out_data.unit_x !== exp_res.unit_x ||
                    out_data.unit_y !== exp_res.unit_y ||
                    out_data.unit_z !== exp_res.unit_z ||
                    out_data.length !== exp_res.length ||
                    out_data.was_zeroed !== exp_res.was_zeroed)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: expected %p actual %p", exp_res, out_data);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt == WATCH_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] set_list [5];
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        err_cnt    = 0;
        hold_req   = 1'b0;
        send_burst = 1'b0;
        idle_cnt   = 0;
        cur_thresh = THRESH_RESET;

        // extremes and special cases; results typed in where obvious
        dir_rows[0]  = '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1,
                         '{16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1}};
        dir_rows[1]  = '{'{16'sd256, 16'sd0, 16'sd0}, 1'b1,
                         '{16'sd16384, 16'sd0, 16'sd0, 16'd256, 1'b0}};
        dir_rows[2]  = '{'{16'sd0, -16'sd256, 16'sd0}, 1'b1,
                         '{16'sd0, -16'sd16384, 16'sd0, 16'd256, 1'b0}};
        dir_rows[3]  = '{'{16'sd0, 16'sd0, 16'sd32767}, 1'b1,
                         '{16'sd0, 16'sd0, 16'sd16384, 16'd32767, 1'b0}};
        dir_rows[4]  = '{'{-16'sd32768, 16'sd0, 16'sd0}, 1'b1,
                         '{-16'sd16384, 16'sd0, 16'sd0, 16'd32768, 1'b0}};
        dir_rows[5]  = '{'{16'sd1, 16'sd0, 16'sd0}, 1'b1,
                         '{16'sd16384, 16'sd0, 16'sd0, 16'd1, 1'b0}};
        dir_rows[6]  = '{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '{default: '0}};
        dir_rows[7]  = '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '{default: '0}};
        dir_rows[8]  = '{'{16'sd32767, -16'sd32768, 16'sd1}, 1'b0, '{default: '0}};
        dir_rows[9]  = '{'{16'sd3, 16'sd4, 16'sd0}, 1'b0, '{default: '0}};
        dir_rows[10] = '{'{16'sd1, 16'sd1, 16'sd1}, 1'b0, '{default: '0}};
        dir_rows[11] = '{'{-16'sd1, -16'sd1, -16'sd1}, 1'b0, '{default: '0}};
        dir_rows[12] = '{'{16'sd100, -16'sd200, 16'sd300}, 1'b0, '{default: '0}};
        dir_rows[13] = '{'{16'sd0, 16'sd1, -16'sd1}, 1'b0, '{default: '0}};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            push_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);
        in_valid <= 1'b0;
        wait_idle();

        // threshold settings, extremes included
        set_list[0] = 16'd0;
        set_list[1] = 16'hffff;
        set_list[2] = 16'd512;
        set_list[3] = 16'($urandom);
        set_list[4] = 16'd1;
        for (int s = 0; s < 5; s++)
        begin
            apb_write(3'(ADDR_THRESH), {16'($urandom), set_list[s]});
            // a write to an unused address must leave the threshold alone
            if (s == 2)
                apb_write(ADDR_SPARE, $urandom);
            // long receiver hold-off so the pipe fills and stalls its input
            if (s == 3)
                hold_req = 1'b1;
            for (int n = 0; n < RAND_PER_SET; n++)
                push_request(pick_request(), 1'b0, '{default: '0});
            in_valid <= 1'b0;
            wait_idle();
        end

        if (err_cnt == 0 && pending_units.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
